// ===== hdl/ple_pkg.sv =====
// ============================================================================
// ple_pkg
// Types and constants shared by the positional list engine.
// ============================================================================
`default_nettype none

package ple_pkg;

    // Maximum number of entries held by the list.
    localparam int CAPACITY = 64;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int CNT_OUT_W = 7;
    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW     = $clog2(CAPACITY + 1);
    // Width that holds both a position and a count plus one without overflow.
    localparam int CMPW   = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0]    read_value;
        logic [1:0]           status;
        logic [CNT_OUT_W-1:0] count;
        logic                 is_empty;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [DATA_W-1:0] wdata;
        logic [AW-1:0]     raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== hdl/ple_ram.sv =====
// ============================================================================
// ple_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/ple_seq.sv =====
// ============================================================================
// ple_seq
// Request sequencer: checks positions against the count, runs reads and
// overwrites, and moves entries one per cycle for insert and remove.
// ============================================================================
`default_nettype none

module ple_seq
    import ple_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_ready,
    input  wire t_in      i_req,
    output t_ram_req      o_ram,
    input  wire logic [DATA_W-1:0] i_rdata,
    output logic          o_res_valid,
    input  wire logic     i_res_ready,
    output t_out          o_res
);

    t_state            r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [DATA_W-1:0] r_val, n_val;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_src, n_src;
    logic [AW-1:0]     r_last, n_last;
    logic [CW-1:0]     r_left, n_left;
    logic              r_pend, n_pend;
    logic [DATA_W-1:0] r_rd, n_rd;
    t_status           r_st, n_st;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            in_list;
    logic            ins_ok;
    logic            full;
    logic [AW-1:0]   pos_addr;

    assign pos_ext  = CMPW'(r_pos);
    assign cnt_ext  = CMPW'(r_count);
    assign in_list  = (r_pos != '0) && (pos_ext <= cnt_ext);
    assign ins_ok   = (r_pos != '0) && (pos_ext <= cnt_ext + CMPW'(1));
    assign full     = (r_count == CW'(CAPACITY));
    assign pos_addr = AW'(pos_ext - CMPW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_src  <= n_src;
        r_last <= n_last;
        r_left <= n_left;
        r_rd   <= n_rd;
        r_st   <= n_st;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_pos   = r_pos;
        n_val   = r_val;
        n_count = r_count;
        n_src   = r_src;
        n_last  = r_last;
        n_left  = r_left;
        n_pend  = 1'b0;
        n_rd    = r_rd;
        n_st    = r_st;
        o_ram.we    = 1'b0;
        o_ram.waddr = pos_addr;
        o_ram.wdata = r_val;
        o_ram.raddr = r_src;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op    = i_req.opcode;
                    n_pos   = i_req.position;
                    n_val   = i_req.value;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rd    = '0;
                n_st    = ST_OK;
                n_state = S_DONE;
                case (t_op'(r_op))
                    OP_READ: begin
                        o_ram.raddr = pos_addr;
                        if (in_list) begin
                            n_state = S_RDWAIT;
                        end else begin
                            n_rd = '1;
                            n_st = ST_RANGE;
                        end
                    end
                    OP_WRITE: begin
                        if (in_list) begin
                            o_ram.we = 1'b1;
                        end else begin
                            n_st = ST_RANGE;
                        end
                    end
                    OP_INSERT: begin
                        if (!ins_ok) begin
                            n_st = ST_RANGE;
                        end else if (full) begin
                            n_st = ST_FULL;
                        end else begin
                            // Walk from the last entry down to the position.
                            n_src   = AW'(cnt_ext - CMPW'(1));
                            n_left  = CW'(cnt_ext - pos_ext + CMPW'(1));
                            n_state = S_SHIFT;
                        end
                    end
                    OP_REMOVE: begin
                        if (in_list) begin
                            // Walk from the entry after the position up to the end.
                            n_src   = AW'(pos_ext);
                            n_left  = CW'(cnt_ext - pos_ext);
                            n_state = S_SHIFT;
                        end else begin
                            n_st = ST_RANGE;
                        end
                    end
                    default: begin
                        n_st = ST_RANGE;
                    end
                endcase
            end
            S_RDWAIT: begin
                n_rd    = i_rdata;
                n_state = S_DONE;
            end
            S_SHIFT: begin
                // Read one entry per cycle; its data is written one slot over in the
                // next cycle, so read and write addresses never meet.
                if (r_left != '0) begin
                    o_ram.raddr = r_src;
                    n_last      = r_src;
                    n_pend      = 1'b1;
                    n_left      = r_left - CW'(1);
                    n_src       = (t_op'(r_op) == OP_INSERT) ? r_src - AW'(1)
                                                             : r_src + AW'(1);
                end
                if (r_pend) begin
                    o_ram.we    = 1'b1;
                    o_ram.wdata = i_rdata;
                    o_ram.waddr = (t_op'(r_op) == OP_INSERT) ? r_last + AW'(1)
                                                             : r_last - AW'(1);
                end else if (r_left == '0) begin
                    if (t_op'(r_op) == OP_INSERT) begin
                        o_ram.we = 1'b1;
                        n_count  = r_count + CW'(1);
                    end else begin
                        n_count  = r_count - CW'(1);
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready      = (r_state == S_IDLE);
    assign o_res_valid      = (r_state == S_DONE);
    assign o_res.read_value = r_rd;
    assign o_res.status     = r_st;
    assign o_res.count      = CNT_OUT_W'(r_count);
    assign o_res.is_empty   = (r_count == '0);

endmodule

`default_nettype wire

// ===== hdl/positional_list_engine_unit.sv =====
// ============================================================================
// positional_list_engine_unit
// Bounded list of signed 32-bit values addressed by 1-based position, with
// read, overwrite, insert and remove requests and one result per request.
// ============================================================================
//   Channel | Valid       | Ready       | Payload
//   request | i_in_valid  | o_in_ready  | i_in_data  (t_in)
//   result  | o_out_valid | i_out_ready | o_out_data (t_out)
//
// A request beat is taken while idle and executed; a read then waits for the
// registered RAM data, and an insert or remove first shifts moves entries, one
// per cycle through the read and write ports of the element RAM, where moves is
// at most CAPACITY - 1. Each result is then held in the output register.
// Reset clears the count and the control state; the RAM is not cleared.
// A held result beat does not block the next request until the sequencer
// finishes that request and needs the output register again.
`default_nettype none

module positional_list_engine_unit
    import ple_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_ram_req          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    t_out              res;

    logic r_out_valid, n_out_valid;
    t_out r_out_data, n_out_data;

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    ple_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in_data),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (res_ready) begin
            n_out_valid = res_valid;
            n_out_data  = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
